// ===== hdl/ramped_pulse_train_generator_core_macros.svh =====
// Assertion macros used by the pulse train generator core RTL.
`ifndef RAMPED_PULSE_TRAIN_GENERATOR_CORE_MACROS_SVH
`define RAMPED_PULSE_TRAIN_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPTG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RPTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/rptg_pkg.sv =====
// Shared types, register codes and reset values of the pulse train generator.
package rptg_pkg;

    // Default widths of the timing and pulse counters
    localparam int TIME_BITS_DEF  = 20;
    localparam int COUNT_BITS_DEF = 8;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_FIRST_WIDTH    = 3'd0;
    localparam logic [2:0] REG_WIDTH_STEP     = 3'd1;
    localparam logic [2:0] REG_PULSE_COUNT    = 3'd2;
    localparam logic [2:0] REG_OFF_TIME       = 3'd3;
    localparam logic [2:0] REG_IDLE_TIME      = 3'd4;
    localparam logic [2:0] REG_SYNC_ON_TIME   = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE_DELAY = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_FIRST_WIDTH    = 16'd800;
    localparam logic [11:0] RST_WIDTH_STEP     = 12'd50;
    localparam logic [7:0]  RST_PULSE_COUNT    = 8'd16;
    localparam logic [19:0] RST_OFF_TIME       = 20'd1200;
    localparam logic [19:0] RST_IDLE_TIME      = 20'd6500;
    localparam logic [15:0] RST_SYNC_ON_TIME   = 16'd50;
    localparam logic [19:0] RST_DEBOUNCE_DELAY = 20'd200000;

    // Live configuration handed to the datapath
    typedef struct packed {
        logic [15:0] first_width;
        logic [11:0] width_step;
        logic [7:0]  pulse_count;
        logic [19:0] off_time;
        logic [19:0] idle_time;
        logic [15:0] sync_on_time;
        logic [19:0] debounce_delay;
    } t_cfg;

    // One result item, data_level in the lowest bit
    typedef struct packed {
        logic       descending;
        logic       output_enabled;
        logic [7:0] pulse_number;
        logic       sync_level;
        logic       data_level;
    } t_result;

endpackage

// ===== hdl/ramped_pulse_train_generator_core.sv =====
// A transferred tick is held in the input register, then moves into the result register once that is free or drains.
// Throughput: one tick per cycle back to back; only a stalled result side slows the input.
// The input register takes a new tick while a finished result still waits on the output, if it holds no tick itself.
// Reset: synchronous, active low; registers return to defaults, enable and direction clear,
// the frame restarts in the sync phase and both debounce timers clear.
`include "ramped_pulse_train_generator_core_macros.svh"

module ramped_pulse_train_generator_core #(
    parameter int TIME_BITS  = rptg_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = rptg_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] enable_press, [1] select_press, rest zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] data_level, [1] sync_level, [9:2] pulse_number,
                                   // [10] output_enabled, [11] descending, rest zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rptg_pkg::t_cfg    w_cfg;
    rptg_pkg::t_result w_result;
    rptg_pkg::t_result r_result;
    logic              r_in_valid;
    logic [1:0]        r_in_press;
    logic              r_out_valid;
    logic              w_adv;
    logic              w_enable_next;
    logic              w_down_next;

    rptg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Move a tick on when the result register is free or drains this cycle
    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    // Hold the accepted tick in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_press <= s_tdata[1:0];
        end
    end

    rptg_debounce #(.TIME_BITS(TIME_BITS)) u_enable_db (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_press     (r_in_press[0]),
        .i_delay     (w_cfg.debounce_delay),
        .o_flag_next (w_enable_next)
    );

    rptg_debounce #(.TIME_BITS(TIME_BITS)) u_select_db (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_press     (r_in_press[1]),
        .i_delay     (w_cfg.debounce_delay),
        .o_flag_next (w_down_next)
    );

    rptg_sequencer #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_cfg         (w_cfg),
        .i_enable_next (w_enable_next),
        .i_down_next   (w_down_next),
        .o_result      (w_result)
    );

    // Load the result register, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_result};

    // SYNC and DATA are never high together
    `RPTG_ASSERT_SAME(a_sync_data_excl, i_clk, i_rst_n, m_tvalid, !(m_tdata[0] && m_tdata[1]))
    // No pulse number is shown during the sync phase
    `RPTG_ASSERT_SAME(a_sync_no_pulse, i_clk, i_rst_n, m_tvalid && m_tdata[1], m_tdata[9:2] == 8'd0)
    // A waiting tick in the input register is kept intact
    `RPTG_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_press))

endmodule

// ===== hdl/rptg_cfg_regs.sv =====
// APB-style configuration register file of the pulse train generator.
module rptg_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output rptg_pkg::t_cfg o_cfg
);

    rptg_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic           w_write;

    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_width    <= rptg_pkg::RST_FIRST_WIDTH;
            r_cfg.width_step     <= rptg_pkg::RST_WIDTH_STEP;
            r_cfg.pulse_count    <= rptg_pkg::RST_PULSE_COUNT;
            r_cfg.off_time       <= rptg_pkg::RST_OFF_TIME;
            r_cfg.idle_time      <= rptg_pkg::RST_IDLE_TIME;
            r_cfg.sync_on_time   <= rptg_pkg::RST_SYNC_ON_TIME;
            r_cfg.debounce_delay <= rptg_pkg::RST_DEBOUNCE_DELAY;
        end else if (w_write) begin
            case (w_index)
                rptg_pkg::REG_FIRST_WIDTH:    r_cfg.first_width    <= pwdata[15:0];
                rptg_pkg::REG_WIDTH_STEP:     r_cfg.width_step     <= pwdata[11:0];
                rptg_pkg::REG_PULSE_COUNT:    r_cfg.pulse_count    <= pwdata[7:0];
                rptg_pkg::REG_OFF_TIME:       r_cfg.off_time       <= pwdata[19:0];
                rptg_pkg::REG_IDLE_TIME:      r_cfg.idle_time      <= pwdata[19:0];
                rptg_pkg::REG_SYNC_ON_TIME:   r_cfg.sync_on_time   <= pwdata[15:0];
                rptg_pkg::REG_DEBOUNCE_DELAY: r_cfg.debounce_delay <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero beyond the list
    always_comb begin
        case (w_index)
            rptg_pkg::REG_FIRST_WIDTH:    prdata = {16'd0, r_cfg.first_width};
            rptg_pkg::REG_WIDTH_STEP:     prdata = {20'd0, r_cfg.width_step};
            rptg_pkg::REG_PULSE_COUNT:    prdata = {24'd0, r_cfg.pulse_count};
            rptg_pkg::REG_OFF_TIME:       prdata = {12'd0, r_cfg.off_time};
            rptg_pkg::REG_IDLE_TIME:      prdata = {12'd0, r_cfg.idle_time};
            rptg_pkg::REG_SYNC_ON_TIME:   prdata = {16'd0, r_cfg.sync_on_time};
            rptg_pkg::REG_DEBOUNCE_DELAY: prdata = {12'd0, r_cfg.debounce_delay};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/rptg_debounce.sv =====
// Press debouncer with saturating quiet timer and toggle flag.
module rptg_debounce #(
    parameter int TIME_BITS = rptg_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_press,
    input  logic [19:0] i_delay,
    output logic        o_flag_next
);

    localparam int WW = 33;
    localparam logic [WW-1:0] TIME_MAX = (WW'(1) << TIME_BITS) - WW'(1);

    logic [TIME_BITS-1:0] r_timer;
    logic [TIME_BITS-1:0] n_timer;
    logic                 r_flag;
    logic [WW-1:0]        w_inc;
    logic [TIME_BITS-1:0] w_sat;
    logic                 w_accept;

    // Advance the quiet timer and judge the press against the delay
    always_comb begin
        w_inc       = WW'(r_timer) + WW'(1);
        w_sat       = (w_inc > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : w_inc[TIME_BITS-1:0];
        w_accept    = i_press && (WW'(w_sat) > WW'(i_delay));
        n_timer     = w_accept ? '0 : w_sat;
        o_flag_next = r_flag ^ w_accept;
    end

    // Hold timer and flag between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_timer <= n_timer;
            r_flag  <= o_flag_next;
        end
    end

endmodule

// ===== hdl/rptg_sequencer.sv =====
// Frame sequencer: sync, pulse-on, pulse-off and idle phases with ramped widths.
module rptg_sequencer #(
    parameter int TIME_BITS  = rptg_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = rptg_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rptg_pkg::t_cfg    i_cfg,
    input  logic              i_enable_next,
    input  logic              i_down_next,
    output rptg_pkg::t_result o_result
);

    localparam int WW = 33;
    localparam int NW = (COUNT_BITS + 1 > 9) ? COUNT_BITS + 1 : 9;
    localparam int PW = NW + 12;
    localparam logic [WW-1:0] TIME_MAX  = (WW'(1) << TIME_BITS) - WW'(1);
    localparam logic [NW-1:0] COUNT_MAX = (NW'(1) << COUNT_BITS) - NW'(1);

    typedef enum logic [1:0] {PH_SYNC, PH_ON, PH_OFF, PH_IDLE} t_phase;

    t_phase                r_phase,  n_phase;
    logic [TIME_BITS-1:0]  r_timer,  n_timer;
    logic [COUNT_BITS-1:0] r_index,  n_index;
    logic [TIME_BITS-1:0]  r_width,  n_width;
    logic                  r_latch,  n_latch;

    logic [NW-1:0]         w_eff;
    logic [NW-1:0]         w_index_ext;
    logic [NW-1:0]         w_cand;
    logic                  w_cand_ok;
    logic                  w_start_ok;
    logic [NW-1:0]         w_cand_m1;
    logic [PW-1:0]         w_prod;
    logic [TIME_BITS-1:0]  w_new_width;
    logic [TIME_BITS-1:0]  w_dur;
    logic [TIME_BITS-1:0]  w_timer_inc;
    logic                  w_done;

    // Saturate to the timer range
    function automatic logic [TIME_BITS-1:0] sat_time(input logic [WW-1:0] v);
        sat_time = (v > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : v[TIME_BITS-1:0];
    endfunction

    // Saturate and treat zero as one tick
    function automatic logic [TIME_BITS-1:0] at_least_one(input logic [WW-1:0] v);
        logic [TIME_BITS-1:0] s;
        s = sat_time(v);
        at_least_one = (s == '0) ? TIME_BITS'(1) : s;
    endfunction

    // Show the current phase on the result
    always_comb begin
        w_index_ext             = NW'(r_index);
        o_result.data_level     = (r_phase == PH_ON) ? r_latch : 1'b0;
        o_result.sync_level     = (r_phase == PH_SYNC);
        o_result.pulse_number   = ((r_phase == PH_ON) || (r_phase == PH_OFF)) ?
                                  w_index_ext[7:0] : 8'd0;
        o_result.output_enabled = i_enable_next;
        o_result.descending     = i_down_next;
    end

    // Pick the next pulse number and its width
    always_comb begin
        w_eff = (NW'(i_cfg.pulse_count) > COUNT_MAX) ? COUNT_MAX : NW'(i_cfg.pulse_count);
        if (r_phase == PH_SYNC) begin
            w_cand    = i_down_next ? w_eff : NW'(1);
            w_cand_ok = 1'b1;
        end else if (i_down_next) begin
            w_cand    = w_index_ext - NW'(1);
            w_cand_ok = (r_index != '0);
        end else begin
            w_cand    = w_index_ext + NW'(1);
            w_cand_ok = 1'b1;
        end
        w_start_ok  = w_cand_ok && (w_cand != '0) && (w_cand <= w_eff);
        w_cand_m1   = w_cand - NW'(1);
        w_prod      = PW'(w_cand_m1) * PW'(i_cfg.width_step);
        w_new_width = sat_time(WW'(i_cfg.first_width) + WW'(w_prod));
    end

    // Advance the phase timer and change phase when the duration is reached
    always_comb begin
        case (r_phase)
            PH_SYNC: w_dur = at_least_one(WW'(i_cfg.sync_on_time));
            PH_ON:   w_dur = at_least_one(WW'(r_width));
            PH_OFF:  w_dur = at_least_one(WW'(i_cfg.off_time));
            default: w_dur = at_least_one(WW'(i_cfg.idle_time));
        endcase
        w_timer_inc = sat_time(WW'(r_timer) + WW'(1));
        w_done      = (w_timer_inc >= w_dur);

        n_phase = r_phase;
        n_timer = w_timer_inc;
        n_index = r_index;
        n_width = r_width;
        n_latch = r_latch;

        if (w_done) begin
            case (r_phase)
                PH_ON: begin
                    n_phase = PH_OFF;
                    n_timer = '0;
                end
                PH_SYNC, PH_OFF: begin
                    n_timer = '0;
                    if (w_start_ok) begin
                        n_phase = PH_ON;
                        n_index = w_cand[COUNT_BITS-1:0];
                        n_width = w_new_width;
                        n_latch = i_enable_next;
                    end else begin
                        n_phase = (i_cfg.idle_time == '0) ? PH_SYNC : PH_IDLE;
                        n_index = '0;
                    end
                end
                default: begin
                    n_phase = PH_SYNC;
                    n_timer = '0;
                    n_index = '0;
                end
            endcase
        end
    end

    // Hold the sequencer state between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_timer <= '0;
            r_index <= '0;
            r_width <= '0;
            r_latch <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_index <= n_index;
            r_width <= n_width;
            r_latch <= n_latch;
        end
    end

endmodule
